// File: rtl/lbsi_pkg.sv
// lbsi_pkg: shared types, widths and codes for the line/box slab intersection core
// used by every module of the block; depends on nothing

package lbsi_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int TOL_W     = 31;
    // exact bound - point difference, scaled by 2^FRAC_BITS
    localparam int DIFF_W    = COORD_W + 1;
    localparam int NUM_W     = DIFF_W + FRAC_BITS;
    // comparisons with the tolerance added
    localparam int CMP_W     = COORD_W + 2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_MISS      = 2'd1;
    localparam logic [1:0] STAT_UNBOUNDED = 2'd2;

    // one input item: one dimension of the query
    typedef struct packed {
        logic signed [COORD_W-1:0] point_coord;
        logic signed [COORD_W-1:0] dir_coord;
        logic signed [COORD_W-1:0] box_lower;
        logic signed [COORD_W-1:0] box_upper;
        logic                      last;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic signed [COORD_W-1:0] t_enter;
        logic signed [COORD_W-1:0] t_exit;
        logic [1:0]                status;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start_div;
        logic sel_hi;
        logic store_a;
        logic store_b;
        logic fold;
        logic par_update;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic parallel;
        logic div_done;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/lbsi_div.sv
// lbsi_div: shared radix-2 signed divider, one quotient bit per cycle, saturating result
// depends on lbsi_pkg

module lbsi_div
    import lbsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [NUM_W-1:0]   num,
    input  logic signed [COORD_W-1:0] den,
    output logic                      done,
    output logic signed [COORD_W-1:0] quo
);

    localparam int QW    = COORD_W;
    localparam int REM_W = QW + 1;
    localparam int HI_W  = NUM_W - QW;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);
    localparam logic [REM_W-1:0] POS_LIMIT = REM_W'((64'd1 << (QW - 1)) - 64'd1);
    localparam logic [REM_W-1:0] NEG_LIMIT = REM_W'(64'd1 << (QW - 1));
    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_PREP = 4'b0010,
        D_RUN  = 4'b0100,
        D_FIN  = 4'b1000
    } div_state_t;

    div_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [NUM_W-1:0]       nmag_reg, nmag_next;
    logic [QW-1:0]          dmag_reg, dmag_next;
    logic                   neg_reg, neg_next;
    logic                   sat_reg, sat_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [QW-1:0]          qsh_reg, qsh_next;
    logic signed [QW-1:0]   quo_reg, quo_next;

    logic [REM_W-1:0]       rem_sh;
    logic                   ge;
    logic [REM_W-1:0]       qmag;

    // one restoring step
    assign rem_sh = {rem_reg[QW-1:0], qsh_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, dmag_reg};
    assign qmag   = {1'b0, qsh_reg};

    // sequencing and datapath of the divider
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        nmag_next  = nmag_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        rem_next   = rem_reg;
        qsh_next   = qsh_reg;
        quo_next   = quo_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    nmag_next  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    dmag_next  = den[QW-1] ? QW'(-den) : QW'(den);
                    neg_next   = num[NUM_W-1] ^ den[QW-1];
                    state_next = D_PREP;
                end
            end
            D_PREP:
            begin
                // quotient of 2^QW or more always saturates
                sat_next   = REM_W'(nmag_reg[NUM_W-1:QW]) >= {1'b0, dmag_reg};
                rem_next   = REM_W'(nmag_reg[NUM_W-1:QW]);
                qsh_next   = nmag_reg[QW-1:0];
                cnt_next   = '0;
                state_next = D_RUN;
            end
            D_RUN:
            begin
                rem_next = ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
                qsh_next = {qsh_reg[QW-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = D_FIN;
                end
            end
            D_FIN:
            begin
                // sign and clamp
                if (sat_reg)
                begin
                    quo_next = neg_reg ? Q_MIN : Q_MAX;
                end
                else if (neg_reg)
                begin
                    quo_next = (qmag > NEG_LIMIT) ? Q_MIN : QW'(-qmag);
                end
                else
                begin
                    quo_next = (qmag > POS_LIMIT) ? Q_MAX : qsh_reg;
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        qsh_reg  <= qsh_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/lbsi_datapath.sv
// lbsi_datapath: item and tolerance registers, running entry/exit state, output register
// depends on lbsi_pkg and lbsi_div

module lbsi_datapath
    import lbsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  in_item_t         in_data,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    in_item_t                   item_reg;
    logic [TOL_W-1:0]           tol_reg;
    logic signed [COORD_W-1:0]  a_reg;
    logic signed [COORD_W-1:0]  b_reg;
    logic signed [COORD_W-1:0]  run_enter_reg, run_enter_next;
    logic signed [COORD_W-1:0]  run_exit_reg, run_exit_next;
    logic                       enter_fin_reg, enter_fin_next;
    logic                       exit_fin_reg, exit_fin_next;
    logic                       miss_reg, miss_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_reg, out_next;

    logic signed [CMP_W-1:0]    tol_s;
    logic signed [CMP_W-1:0]    p_s, lo_s, hi_s, dir_s, dir_abs;
    logic                       par_miss;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [NUM_W-1:0]    div_num;
    logic                       div_done;
    logic signed [COORD_W-1:0]  div_quo;
    logic signed [COORD_W-1:0]  slab_min, slab_max;
    logic                       overlap_miss;

    // widened operands for the tolerance compares
    assign tol_s   = $signed({{(CMP_W-TOL_W){1'b0}}, tol_reg});
    assign p_s     = CMP_W'(item_reg.point_coord);
    assign lo_s    = CMP_W'(item_reg.box_lower);
    assign hi_s    = CMP_W'(item_reg.box_upper);
    assign dir_s   = CMP_W'(item_reg.dir_coord);
    assign dir_abs = dir_s[CMP_W-1] ? -dir_s : dir_s;

    // parallel test and slab containment
    assign par_miss = (p_s < lo_s - tol_s) || (p_s > hi_s + tol_s);

    // numerator for the selected bound
    assign diff    = (cmd.sel_hi ? DIFF_W'(item_reg.box_upper) : DIFF_W'(item_reg.box_lower))
                     - DIFF_W'(item_reg.point_coord);
    assign div_num = {diff, {FRAC_BITS{1'b0}}};

    lbsi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   (div_num),
        .den   (item_reg.dir_coord),
        .done  (div_done),
        .quo   (div_quo)
    );

    // order the two slab parameters
    assign slab_min = (a_reg > b_reg) ? b_reg : a_reg;
    assign slab_max = (a_reg > b_reg) ? a_reg : b_reg;

    // final overlap check
    assign overlap_miss = CMP_W'(run_enter_reg) > (CMP_W'(run_exit_reg) + tol_s);

    // running state update and result formation
    always_comb
    begin
        run_enter_next = run_enter_reg;
        run_exit_next  = run_exit_reg;
        enter_fin_next = enter_fin_reg;
        exit_fin_next  = exit_fin_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (cmd.par_update && par_miss)
        begin
            miss_next = 1'b1;
        end
        if (cmd.fold)
        begin
            if (!enter_fin_reg || slab_min > run_enter_reg)
            begin
                run_enter_next = slab_min;
                enter_fin_next = 1'b1;
            end
            if (!exit_fin_reg || slab_max < run_exit_reg)
            begin
                run_exit_next = slab_max;
                exit_fin_next = 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_valid_next   = 1'b1;
            out_next.t_enter = '0;
            out_next.t_exit  = '0;
            if (miss_reg)
            begin
                out_next.status = STAT_MISS;
            end
            else if (!enter_fin_reg || !exit_fin_reg)
            begin
                out_next.status = STAT_UNBOUNDED;
            end
            else if (overlap_miss)
            begin
                out_next.status = STAT_MISS;
            end
            else
            begin
                out_next.status  = STAT_OK;
                out_next.t_enter = run_enter_reg;
                out_next.t_exit  = run_exit_reg;
            end
            // clear for the next query
            run_enter_next = '0;
            run_exit_next  = '0;
            enter_fin_next = 1'b0;
            exit_fin_next  = 1'b0;
            miss_next      = 1'b0;
        end
    end

    // control and query state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TOL_W'(1);
            run_enter_reg <= '0;
            run_exit_reg  <= '0;
            enter_fin_reg <= 1'b0;
            exit_fin_reg  <= 1'b0;
            miss_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            run_enter_reg <= run_enter_next;
            run_exit_reg  <= run_exit_next;
            enter_fin_reg <= enter_fin_next;
            exit_fin_reg  <= exit_fin_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.store_a)
        begin
            a_reg <= div_quo;
        end
        if (cmd.store_b)
        begin
            b_reg <= div_quo;
        end
        out_reg <= out_next;
    end

    // status to the controller
    assign stat.parallel = (dir_abs <= tol_s);
    assign stat.div_done = div_done;
    assign stat.last     = item_reg.last;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/lbsi_ctrl.sv
// lbsi_ctrl: sequencer for one dimension: parallel test or two divisions, fold, emit
// depends on lbsi_pkg

module lbsi_ctrl
    import lbsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_DIV_LO = 6'b000100,
        S_DIV_HI = 6'b001000,
        S_FOLD   = 6'b010000,
        S_DONE   = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.parallel)
                begin
                    cmd.par_update = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV_LO;
                end
            end
            S_DIV_LO:
            begin
                if (stat.div_done)
                begin
                    cmd.store_a   = 1'b1;
                    cmd.start_div = 1'b1;
                    cmd.sel_hi    = 1'b1;
                    state_next    = S_DIV_HI;
                end
            end
            S_DIV_HI:
            begin
                if (stat.div_done)
                begin
                    cmd.store_b = 1'b1;
                    state_next  = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/line_box_slab_intersection_core.sv
// Slab test of a line against an axis-aligned box, one dimension per item, Q16.16 values.
// An item whose direction is within the tolerance of zero needs only the parallel test;
// any other item runs two 32-step divisions, one after the other, on the single shared
// radix-2 divider. One item is worked on at a time. The result of a query (item with last
// set) sits in an output register, so the next query may start while it waits to be taken;
// a closing item waits in addition while the previous result still occupies that register.
// depends on lbsi_pkg, lbsi_ctrl, lbsi_datapath

module line_box_slab_intersection_core
    import lbsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    lbsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and state
    lbsi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: rtl/lbsi_checker.sv
// lbsi_checker: port-level checks of the slab intersection core, bound to the top level
// depends on lbsi_pkg and line_box_slab_intersection_core

module lbsi_checker
    import lbsi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_MISS ||
                       out_data.status == STAT_UNBOUNDED))
        else $error("undefined status code");

    // no intersection means zero parameters
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |->
            out_data.t_enter == '0 && out_data.t_exit == '0)
        else $error("nonzero parameters without intersection");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an item was accepted");

endmodule

bind line_box_slab_intersection_core lbsi_checker u_lbsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/line_box_slab_intersection_checker.sv
`timescale 1ns / 1ps
// Checker for the line/box slab intersection core: watches the config port and both
// item channels, predicts each query result and compares it field by field.
// depends on lbsi_pkg

module line_box_slab_intersection_checker
    import lbsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_item_t        out_data,
    input  logic             wrap_up,
    output int               pending,
    output int               fail_count,
    output int               n_hit,
    output int               n_miss,
    output int               n_unbounded
);

    // predictor state: tolerance and running entry/exit of the open query
    logic [TOL_W-1:0] tol_q;
    longint           enter_t;
    longint           exit_t;
    bit               enter_known;
    bit               exit_known;
    bit               slab_missed;
    out_item_t        expected_hits[$];
    int               fault_total;
    int               hit_total;
    int               miss_total;
    int               unb_total;
    bit               wrapped;

    // slab crossing parameter, truncated toward zero and clamped to 32 bits
    function automatic longint slab_crossing(longint bound, longint base, longint dir);
        longint num;
        longint q;
        num = (bound - base) * (longint'(1) << FRAC_BITS);
        q = num / dir;
        if (q > longint'(32'sh7FFF_FFFF))
            q = longint'(32'sh7FFF_FFFF);
        if (q < longint'(32'sh8000_0000))
            q = longint'(32'sh8000_0000);
        return q;
    endfunction

    task automatic report_fault(input string what, input longint got, input longint want);
        $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
        fault_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        longint    p;
        longint    d;
        longint    lo;
        longint    hi;
        longint    tol;
        longint    mag;
        longint    a;
        longint    b;
        longint    swap;
        out_item_t res;
        out_item_t want;

        if (!rst_n)
        begin
            tol_q = TOL_W'(1);
            enter_t = 0;
            exit_t = 0;
            enter_known = 1'b0;
            exit_known = 1'b0;
            slab_missed = 1'b0;
            expected_hits.delete();
            fault_total = 0;
            hit_total = 0;
            miss_total = 0;
            unb_total = 0;
            wrapped = 1'b0;
            pending <= 0;
            fail_count <= 0;
            n_hit <= 0;
            n_miss <= 0;
            n_unbounded <= 0;
        end
        else
        begin
            // register write
            if (cfg_we)
                tol_q = cfg_wdata;

            // fold an accepted dimension into the open query
            if (in_valid && in_ready)
            begin
                p = longint'($signed(in_data.point_coord));
                d = longint'($signed(in_data.dir_coord));
                lo = longint'($signed(in_data.box_lower));
                hi = longint'($signed(in_data.box_upper));
                tol = longint'(tol_q);
                mag = (d < 0) ? -d : d;
                if (mag <= tol)
                begin
                    // parallel to the slab: only a position test
                    if (p < lo - tol || p > hi + tol)
                        slab_missed = 1'b1;
                end
                else
                begin
                    a = slab_crossing(lo, p, d);
                    b = slab_crossing(hi, p, d);
                    if (a > b)
                    begin
                        swap = a;
                        a = b;
                        b = swap;
                    end
                    if (!enter_known || a > enter_t)
                    begin
                        enter_t = a;
                        enter_known = 1'b1;
                    end
                    if (!exit_known || b < exit_t)
                    begin
                        exit_t = b;
                        exit_known = 1'b1;
                    end
                end

                // closing dimension: form the result and clear the query
                if (in_data.last)
                begin
                    res.t_enter = '0;
                    res.t_exit = '0;
                    if (slab_missed)
                        res.status = STAT_MISS;
                    else if (!enter_known || !exit_known)
                        res.status = STAT_UNBOUNDED;
                    else if (enter_t > exit_t + tol)
                        res.status = STAT_MISS;
                    else
                    begin
                        res.status = STAT_OK;
                        res.t_enter = enter_t[31:0];
                        res.t_exit = exit_t[31:0];
                    end
                    expected_hits.push_back(res);
                    enter_t = 0;
                    exit_t = 0;
                    enter_known = 1'b0;
                    exit_known = 1'b0;
                    slab_missed = 1'b0;
                end
            end

            // compare an accepted result with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                    report_fault("result with no query closed", out_data.status, -1);
                else
                begin
                    want = expected_hits.pop_front();
                    if (out_data.t_enter !== want.t_enter)
                        report_fault("t_enter", longint'($signed(out_data.t_enter)),
                                     longint'($signed(want.t_enter)));
                    if (out_data.t_exit !== want.t_exit)
                        report_fault("t_exit", longint'($signed(out_data.t_exit)),
                                     longint'($signed(want.t_exit)));
                    if (out_data.status !== want.status)
                        report_fault("status", out_data.status, want.status);
                    case (want.status)
                        STAT_OK:   hit_total++;
                        STAT_MISS: miss_total++;
                        default:   unb_total++;
                    endcase
                end
            end

            // end of run: anything still waiting never arrived
            if (wrap_up && !wrapped)
            begin
                while (expected_hits.size() != 0)
                begin
                    want = expected_hits.pop_front();
                    report_fault("result never arrived, status", -1, want.status);
                end
                wrapped = 1'b1;
            end

            pending <= expected_hits.size();
            fail_count <= fault_total;
            n_hit <= hit_total;
            n_miss <= miss_total;
            n_unbounded <= unb_total;
        end
    end

endmodule

// File: tb/tb_line_box_slab_intersection_core.sv
`timescale 1ns / 1ps
// Testbench top for line_box_slab_intersection_core: drives queries, tolerance settings
// and output stalls, and gives the verdict from the checker's failure count.
// depends on lbsi_pkg, line_box_slab_intersection_core, line_box_slab_intersection_checker

module tb_line_box_slab_intersection_core;
    import lbsi_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int CALM_PERIOD  = 40_000;
    localparam int CALM_START   = 26_000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [TOL_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;
    logic             wrap_up;

    int               pending;
    int               fail_count;
    int               n_hit;
    int               n_miss;
    int               n_unbounded;

    int               cycles = 0;
    logic             calm;
    logic [TOL_W-1:0] cur_tol;
    int               items_sent;
    int               queries_sent;
    int               n_settings;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    line_box_slab_intersection_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    line_box_slab_intersection_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .wrap_up     (wrap_up),
        .pending     (pending),
        .fail_count  (fail_count),
        .n_hit       (n_hit),
        .n_miss      (n_miss),
        .n_unbounded (n_unbounded)
    );

    // stretches with no idling on either side
    assign calm = (cycles % CALM_PERIOD) >= CALM_START;

    // cycle count and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d with %0d results outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 7);
    end

    function automatic in_item_t make_dim(logic signed [31:0] p, logic signed [31:0] d,
                                          logic signed [31:0] lo, logic signed [31:0] hi,
                                          logic last);
        in_item_t it;
        it.point_coord = p;
        it.dir_coord = d;
        it.box_lower = lo;
        it.box_upper = hi;
        it.last = last;
        return it;
    endfunction

    // within about +-160.0 in Q16.16
    function automatic logic signed [31:0] small_coord();
        return int'($urandom_range(0, 32'h0140_0000)) - 32'sh00A0_0000;
    endfunction

    function automatic logic signed [31:0] edge_coord();
        case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sh0000_0001;
            4:       return 32'sh0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // one random dimension, mostly well-formed geometry
    function automatic in_item_t random_dim();
        int unsigned      pick;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]      near;
        in_item_t         it;
        pick = $urandom_range(99);
        it.last = 1'b0;
        if (pick < 45)
        begin
            // ordinary box, point often inside it
            lo = small_coord();
            hi = lo + $urandom_range(0, 32'h0008_0000);
            it.box_lower = lo;
            it.box_upper = hi;
            if ($urandom_range(99) < 60)
                it.point_coord = lo + $urandom_range(0, hi - lo);
            else
                it.point_coord = small_coord();
            it.dir_coord = small_coord();
        end
        else if (pick < 60)
        begin
            // direction right at the parallel threshold
            lo = small_coord();
            it.box_lower = lo;
            it.box_upper = lo + $urandom_range(0, 32'h0004_0000);
            it.point_coord = lo + int'($urandom_range(0, 32'h0006_0000)) - 32'sh0001_0000;
            near = {1'b0, cur_tol} + $urandom_range(0, 2) - 1;
            if ($urandom_range(1) == 1)
                near = -near;
            it.dir_coord = near;
        end
        else if (pick < 75)
        begin
            it.point_coord = edge_coord();
            it.dir_coord = edge_coord();
            it.box_lower = edge_coord();
            it.box_upper = edge_coord();
        end
        else
        begin
            it.point_coord = $urandom;
            it.dir_coord = $urandom;
            it.box_lower = $urandom;
            it.box_upper = $urandom;
        end
        return it;
    endfunction

    // present one item, with an occasional gap before it, and wait for acceptance
    task automatic send_item(input in_item_t it);
        if (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (it.last)
            queries_sent++;
    endtask

    // random queries of one to three dimensions, some longer noisy ones
    task automatic run_queries(input int n_items);
        int       sent;
        int       dims;
        in_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            dims = ($urandom_range(99) < 10) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            for (int k = 0; k < dims; k++)
            begin
                it = random_dim();
                it.last = (k == dims - 1);
                send_item(it);
                sent++;
            end
        end
    endtask

    // wait for every result, then let any trailing item finish
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_tol = v;
        n_settings++;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        wrap_up <= 1'b0;
        cur_tol = TOL_W'(1);
        items_sent = 0;
        queries_sent = 0;
        n_settings = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed queries at the reset tolerance
        // point inside the box
        send_item(make_dim(0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 1'b1));
        // two dimensions, negative direction swaps the slab parameters
        send_item(make_dim(0, 32'sh0001_0000, 0, 32'sh0005_0000, 1'b0));
        send_item(make_dim(0, -32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 1'b1));
        // parallel and outside the slab, the next dimension is still folded in
        send_item(make_dim(32'sh0010_0000, 0, 0, 32'sh0001_0000, 1'b0));
        send_item(make_dim(0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 1'b1));
        // only parallel dimensions inside the slab: unbounded
        send_item(make_dim(0, 1, -5, 5, 1'b1));
        // parallel, point past the bound by exactly the tolerance
        send_item(make_dim(7, -1, -5, 6, 1'b0));
        send_item(make_dim(0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 1'b1));
        // parallel, point one past the widened slab
        send_item(make_dim(-7, 1, -5, 6, 1'b1));
        // full-range box with the smallest non-parallel direction saturates
        send_item(make_dim(32'sh8000_0000, 2, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
        // most negative direction
        send_item(make_dim(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh7FFF_FFFF, 1'b1));
        // largest direction with inverted full-range bounds
        send_item(make_dim(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh8000_0000, 1'b1));
        // disjoint parameter ranges
        send_item(make_dim(0, 32'sh0001_0000, 0, 32'sh0001_0000, 1'b0));
        send_item(make_dim(0, 32'sh0001_0000, 32'sh0005_0000, 32'sh0006_0000, 1'b1));
        // entry beyond exit by exactly the tolerance still intersects
        send_item(make_dim(0, 32'sh0001_0000, 0, 32'sh0001_0000, 1'b0));
        send_item(make_dim(0, 32'sh0001_0000, 32'sh0001_0001, 32'sh0002_0000, 1'b1));
        // one step further misses
        send_item(make_dim(0, 32'sh0001_0000, 0, 32'sh0001_0000, 1'b0));
        send_item(make_dim(0, 32'sh0001_0000, 32'sh0001_0002, 32'sh0002_0000, 1'b1));
        // inverted bounds with an ordinary direction
        send_item(make_dim(0, 32'sh0001_0000, 32'sh0003_0000, -32'sh0003_0000, 1'b1));

        // random phases over several tolerances, extremes included
        settle();
        set_tolerance('0);
        run_queries(300);
        settle();
        set_tolerance({TOL_W{1'b1}});
        run_queries(25);
        settle();
        set_tolerance(TOL_W'($urandom_range(0, 32'h0002_0000)));
        run_queries(300);
        settle();
        set_tolerance(TOL_W'(1));
        run_queries(250);
        settle();
        set_tolerance(TOL_W'($urandom));
        run_queries(25);
        settle();

        wrap_up <= 1'b1;
        repeat (3) @(posedge clk);

        $display("covered %0d dimension items in %0d queries under %0d tolerance settings",
                 items_sent, queries_sent, n_settings);
        $display("results checked: %0d intersecting, %0d missed, %0d unbounded",
                 n_hit, n_miss, n_unbounded);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lbsi_pkg.sv
rtl/lbsi_div.sv
rtl/lbsi_datapath.sv
rtl/lbsi_ctrl.sv
rtl/line_box_slab_intersection_core.sv
rtl/lbsi_checker.sv
tb/line_box_slab_intersection_checker.sv
tb/tb_line_box_slab_intersection_core.sv
